// File: sv/gcdu_pkg.sv
// Shared constants and controller/datapath interface types for the GCD unit.
package gcdu_pkg;

    localparam int OPERAND_WIDTH = 64;
    localparam int FIELD_WIDTH   = 64;
    localparam int TWOS_W        = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] t_operand;
    typedef logic [TWOS_W-1:0]        t_twos;

    typedef struct packed {
        logic load;
        logic shift_both;
        logic shift_a;
        logic shift_b;
        logic sub;
        logic finish;
        logic finish_one;
    } t_dp_cmd;

    typedef struct packed {
        logic a_le1;
        logic b_le1;
        logic both_even;
        logic a_even;
        logic b_even;
        logic b_zero;
    } t_dp_status;

endpackage

// File: sv/gcd_unit_core.sv
// Top level of the GCD unit: binary GCD of two unsigned operands.
//
// Usage: drive both operands and raise start while busy is low; the operands
// transfer at that clock edge and busy rises on the next cycle. While busy is
// high, start is ignored.
// The result appears on o_divisor for exactly one cycle with o_done high; the
// receiver cannot stall, so it must take the transfer in that cycle.
// Latency depends on the operands. When either operand is zero or one the result
// (then one) is set from the check state without entering the loop. Otherwise the
// shift/subtract loop does at most one halving or one subtraction per cycle. Every
// subtraction leaves an even value that is halved next unless it is zero, and
// each halving drops a bit from the two operands together, which bounds the loop.
// One item is in flight at a time; busy falls in the cycle that shows o_done,
// so the next item can transfer in that same cycle.
// Operand bits at or above OPERAND_WIDTH are ignored.
// Reset is synchronous and active low; it returns the controller to idle and
// clears o_done. Nothing is kept between items.
module gcd_unit_core
    import gcdu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [FIELD_WIDTH-1:0] i_first_operand,
    input  logic [FIELD_WIDTH-1:0] i_second_operand,
    output logic                   o_done,
    output logic [FIELD_WIDTH-1:0] o_divisor
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    gcdu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    gcdu_datapath u_datapath (
        .i_clk            (i_clk),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .o_divisor        (o_divisor)
    );

endmodule

// File: sv/gcdu_datapath.sv
// Datapath of the GCD unit: operand registers, subtractor, and result register.
module gcdu_datapath
    import gcdu_pkg::*;
(
    input  logic                   i_clk,
    input  logic [FIELD_WIDTH-1:0] i_first_operand,
    input  logic [FIELD_WIDTH-1:0] i_second_operand,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic [FIELD_WIDTH-1:0] o_divisor
);

    t_operand r_a;
    t_operand r_b;
    t_twos    r_twos;
    t_operand r_result;
    logic     a_gt_b;

    assign a_gt_b = r_a > r_b;

    always_comb begin
        o_status.a_le1     = (r_a[OPERAND_WIDTH-1:1] == '0);
        o_status.b_le1     = (r_b[OPERAND_WIDTH-1:1] == '0);
        o_status.both_even = ~(r_a[0] | r_b[0]);
        o_status.a_even    = ~r_a[0];
        o_status.b_even    = ~r_b[0];
        o_status.b_zero    = (r_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_first_operand[OPERAND_WIDTH-1:0];
            r_b    <= i_second_operand[OPERAND_WIDTH-1:0];
            r_twos <= '0;
        end else if (i_cmd.shift_both) begin
            r_a    <= r_a >> 1;
            r_b    <= r_b >> 1;
            r_twos <= r_twos + 1'b1;
        end else if (i_cmd.shift_a) begin
            r_a <= r_a >> 1;
        end else if (i_cmd.shift_b) begin
            r_b <= r_b >> 1;
        end else if (i_cmd.sub) begin
            // Keep the smaller odd value in a; the difference goes to b.
            if (a_gt_b) begin
                r_a <= r_b;
                r_b <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end

        if (i_cmd.finish_one) begin
            r_result <= t_operand'(1);
        end else if (i_cmd.finish) begin
            r_result <= r_a << r_twos;
        end
    end

    assign o_divisor = FIELD_WIDTH'(r_result);

endmodule

// File: sv/gcdu_ctrl.sv
// Controller state machine that sequences the binary GCD steps.
module gcdu_ctrl
    import gcdu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_COMMON,
        S_ODD_A,
        S_REDUCE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                // An operand of zero or one has no factors, so the answer is one.
                if (i_status.a_le1 || i_status.b_le1) begin
                    o_cmd.finish_one = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_COMMON;
                end
            end
            S_COMMON: begin
                if (i_status.both_even) begin
                    o_cmd.shift_both = 1'b1;
                end else begin
                    n_state = S_ODD_A;
                end
            end
            S_ODD_A: begin
                if (i_status.a_even) begin
                    o_cmd.shift_a = 1'b1;
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_status.b_zero) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_status.b_even) begin
                    o_cmd.shift_b = 1'b1;
                end else begin
                    o_cmd.sub = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish | o_cmd.finish_one;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// File: sv/gcdu_checker.sv
// Port-level checker for the GCD unit and its bind to the top level.
module gcdu_checker
    import gcdu_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_done,
    input logic [FIELD_WIDTH-1:0] o_divisor
);

    // An accepted transfer makes the unit busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transfer");

    // A result never arrives in the cycle right after an input transfer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result strobe too early after an input transfer");

    // The unit is idle in the cycle that shows a result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    // A divisor is never zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_divisor != '0))
        else $error("zero divisor reported");

    // Each result is strobed for a single cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

endmodule

bind gcd_unit_core gcdu_checker u_gcdu_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_done    (o_done),
    .o_divisor (o_divisor)
);

// File: verif/gcd_unit_checker.sv
// Checker for the GCD unit: predicts each divisor and compares it with o_divisor.
module gcd_unit_checker
    import gcdu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [FIELD_WIDTH-1:0] i_first_operand,
    input  logic [FIELD_WIDTH-1:0] i_second_operand,
    input  logic                   i_done,
    input  logic [FIELD_WIDTH-1:0] i_divisor,
    output int                     o_mismatches,
    output int                     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    t_operand divisor_q[$];
    int       mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Euclid's method gives the same exact divisor as the binary iteration in the
    // block. An operand of zero or one forces a divisor of one, even gcd(0, x).
    function automatic t_operand common_divisor(input logic [FIELD_WIDTH-1:0] first,
                                                input logic [FIELD_WIDTH-1:0] second);
        t_operand x;
        t_operand y;
        t_operand r;
        x = t_operand'(first);
        y = t_operand'(second);
        if (x <= 1 || y <= 1) begin
            return t_operand'(1);
        end
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    task automatic report_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    // A result and a new transfer can share one edge; the result always belongs
    // to an older item, so it is checked before the new prediction is queued.
    always @(posedge i_clk) begin
        t_operand expected_divisor;
        if (i_rst_n) begin
            if (i_done) begin
                if (divisor_q.size() == 0) begin
                    report_failure($sformatf("divisor %h arrived with nothing pending",
                                             i_divisor));
                end else begin
                    expected_divisor = divisor_q.pop_front();
                    if (t_operand'(i_divisor) !== expected_divisor) begin
                        report_failure($sformatf("divisor mismatch: expected %h, got %h",
                                                 expected_divisor, i_divisor));
                    end
                end
            end
            if (i_start && !i_busy) begin
                divisor_q.push_back(common_divisor(i_first_operand, i_second_operand));
            end
        end
        o_outstanding <= divisor_q.size();
    end

endmodule

// File: verif/gcd_unit_core_tb.sv
// Testbench top for the GCD unit: clock, reset, operand stimulus and verdict.
module gcd_unit_core_tb
    import gcdu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int STEADY_ITEMS   = 300;
    localparam int DIRECTED_ITEMS = 24;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   start            = 1'b0;
    logic [FIELD_WIDTH-1:0] i_first_operand  = '0;
    logic [FIELD_WIDTH-1:0] i_second_operand = '0;
    logic                   busy;
    logic                   o_done;
    logic [FIELD_WIDTH-1:0] o_divisor;
    int                     mismatches;
    int                     outstanding;

    logic [63:0] directed_first [DIRECTED_ITEMS] = '{
        64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1,
        64'h1, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 64'h2,
        64'h2, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, 64'd12, 64'd6,
        64'd48, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
        64'd3, 64'h1000, 64'd17, 64'h1234_5678_9ABC_DEF0
    };
    logic [63:0] directed_second [DIRECTED_ITEMS] = '{
        64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h1,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h1, 64'h2,
        64'h3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000,
        64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'd18, 64'd4,
        64'd180, 64'h7FFF_FFFF, 64'hFFFF_FFFF, 64'h5555_5555_5555_5555,
        64'h8000_0000_0000_0000, 64'h3000, 64'd323, 64'h0FED_CBA9_8765_4320
    };

    gcd_unit_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_done           (o_done),
        .o_divisor        (o_divisor)
    );

    gcd_unit_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_done           (o_done),
        .i_divisor        (o_divisor),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Holds start high with the operands until the block is free to take them.
    task automatic transfer_operands(input logic [63:0] first, input logic [63:0] second);
        i_first_operand  <= first;
        i_second_operand <= second;
        start            <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Many pairs share a nontrivial factor or a power of two, so the result is
    // often more than one and the block's shift and subtract paths are both exercised.
    task automatic pick_operands(output logic [63:0] first, output logic [63:0] second);
        logic [63:0] factor;
        logic [63:0] edge_values [5];
        edge_values = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                        64'h8000_0000_0000_0000, 64'h2, 64'h3};
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
                first  = rand_word();
                second = rand_word();
            end
            5, 6, 7, 8, 9, 10: begin
                factor = rand_word() >> $urandom_range(24, 62);
                first  = factor * (rand_word() >> $urandom_range(30, 63));
                second = factor * (rand_word() >> $urandom_range(30, 63));
            end
            11, 12: begin
                first  = ((rand_word() >> $urandom_range(20, 63)) | 64'h1)
                         << $urandom_range(0, 40);
                second = ((rand_word() >> $urandom_range(20, 63)) | 64'h1)
                         << $urandom_range(0, 40);
            end
            13, 14: begin
                first  = 64'($urandom_range(0, 20));
                second = 64'($urandom_range(0, 20));
            end
            15: begin
                first  = rand_word() >> $urandom_range(0, 63);
                second = first;
            end
            16: begin
                first  = rand_word() >> $urandom_range(4, 63);
                second = first * 64'($urandom_range(2, 9));
            end
            17: begin
                first  = 64'($urandom_range(0, 1));
                second = rand_word();
                if ($urandom_range(0, 1) == 1) begin
                    factor = first;
                    first  = second;
                    second = factor;
                end
            end
            default: begin
                first  = edge_values[$urandom_range(0, 4)];
                second = $urandom_range(0, 1) ? edge_values[$urandom_range(0, 4)]
                                              : rand_word();
            end
        endcase
    endtask

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [63:0] first;
        logic [63:0] second;
        int          pressure_item;
        int          waited;
        pressure_item = $urandom_range(600, 1200);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIRECTED_ITEMS; n++) begin
            transfer_operands(directed_first[n], directed_second[n]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick_operands(first, second);
            transfer_operands(first, second);
            if (n == pressure_item) begin
                // Let the block drain completely before the next transfer. The registered
                // count only takes in the item just sent once its transfer edge has passed.
                start <= 1'b0;
                @(posedge i_clk);
                while (outstanding != 0) begin
                    @(posedge i_clk);
                end
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else if (n < RANDOM_ITEMS - STEADY_ITEMS && $urandom_range(0, 2) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        @(posedge i_clk);

        waited = 0;
        while (outstanding != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (150) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
sv/gcdu_pkg.sv
sv/gcdu_datapath.sv
sv/gcdu_ctrl.sv
sv/gcd_unit_core.sv
sv/gcdu_checker.sv
verif/gcd_unit_checker.sv
verif/gcd_unit_core_tb.sv
